// ===== src/tlru_pkg.sv =====
// shared types, sizes and age helpers for the true-lru victim selector
// no dependencies; imported by true_lru_victim_select_qbs
package tlru_pkg;

    localparam int WAYS         = 16;
    localparam int SETS         = 64;
    localparam int AGE_W        = 4;
    localparam int WAY_W        = 4;
    localparam int SET_W        = $clog2(SETS);
    localparam int MASK_W       = 16;
    localparam int LIMIT_W      = 4;
    localparam int ATT_W        = 3;
    localparam int MAX_ATTEMPTS = 8;
    localparam int WAYS_P2      = 2 ** $clog2(WAYS);

    localparam logic CMD_HIT    = 1'b0;
    localparam logic CMD_VICTIM = 1'b1;

    typedef logic [WAYS*AGE_W-1:0] t_ages;
    typedef logic [AGE_W-1:0]      t_age;
    typedef logic [WAY_W-1:0]      t_way;

    // one node of the largest-age search tree
    typedef struct packed {
        logic ok;
        t_age age;
        t_way idx;
    } t_node;

    function automatic t_age age_of(t_ages ages, t_way w);
        return ages[w*AGE_W +: AGE_W];
    endfunction

    // in every set, way w starts with age w
    function automatic t_ages init_ages();
        t_ages a;
        a = '0;
        for (int w = 0; w < WAYS; w++) begin
            a[w*AGE_W +: AGE_W] = AGE_W'(w);
        end
        return a;
    endfunction

    localparam t_ages AGES_INIT = init_ages();

    // move target to age 0, age every way that was younger by one
    function automatic t_ages to_mru(t_ages ages, t_way target);
        t_ages o;
        t_age  ta;
        t_age  a;
        ta = age_of(ages, target);
        o  = '0;
        for (int w = 0; w < WAYS; w++) begin
            a = ages[w*AGE_W +: AGE_W];
            if (WAY_W'(w) == target) begin
                a = '0;
            end else if (a < ta) begin
                a = a + 1'b1;
            end
            o[w*AGE_W +: AGE_W] = a;
        end
        return o;
    endfunction

endpackage

// ===== src/true_lru_victim_select_qbs.sv =====
// true-lru replacement state with query-based victim selection
// depends on tlru_pkg (sizes, age helpers, search node type)

// Keeps a true-LRU age per way for every set in a single-port memory with
// per-set valid bits, so no clearing pass is needed after reset. Issue a
// command with start while busy is low. A hit update, or a victim taken from
// an invalid way, raises o_result_valid once the command has passed S_LOAD
// and S_EXEC and its result is registered; a victim search spends another
// round in S_EXEC (largest-age search and MRU update) for each rejection.
// The result is shown for exactly one cycle and cannot be stalled; busy is
// already low in that cycle, so the next command may be accepted then. The
// attempt limit (1..8, 0 acts as 1, above 8 acts as 8) is written through
// the cfg channel, which is always ready; the user must write it only while
// no command is in flight, as the block itself does not enforce this.
module true_lru_victim_select_qbs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [tlru_pkg::SET_W-1:0]     i_set_index,
    input  logic [tlru_pkg::WAY_W-1:0]     i_way,
    input  logic [tlru_pkg::MASK_W-1:0]    i_valid_mask,
    input  logic [tlru_pkg::MASK_W-1:0]    i_replaceable_mask,
    input  logic [tlru_pkg::MASK_W-1:0]    i_lower_level_mask,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tlru_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic                           o_result_valid,
    output logic [tlru_pkg::WAY_W-1:0]     o_victim_way,
    output logic [tlru_pkg::AGE_W-1:0]     o_hit_position,
    output logic                           o_used_invalid,
    output logic [tlru_pkg::ATT_W-1:0]     o_attempt_taken,
    output logic [tlru_pkg::ATT_W-1:0]     o_rejections
);
    import tlru_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    t_ages mem [SETS];
    logic [SETS-1:0] r_written;

    logic [1:0]         r_state, n_state;
    logic [LIMIT_W-1:0] r_cfg_limit;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_cmd;
    logic [SET_W-1:0]   r_set;
    t_way               r_way;
    logic [MASK_W-1:0]  r_valid, r_repl, r_lower;
    t_ages              r_rd_data;
    logic               r_rd_written;
    t_ages              r_ages, n_ages;
    logic [ATT_W-1:0]   r_att, n_att;

    logic               r_out_vld;
    t_way               r_out_victim;
    t_age               r_out_hitpos;
    logic               r_out_inv;
    logic [ATT_W-1:0]   r_out_taken, r_out_rej;

    logic               accept;
    logic               finish;
    logic               mem_we;
    t_way               res_victim;
    t_age               res_hitpos;
    logic               res_inv;
    logic               inv_found;
    t_way               inv_way;
    t_node              node [1:2*WAYS_P2-1];
    t_way               pick;
    logic               reject;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // lowest-index invalid way
    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!r_valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
    end

    // largest nonzero replaceable age, lowest index on ties
    always_comb begin
        for (int w = 0; w < WAYS_P2; w++) begin
            if (w < WAYS) begin
                node[WAYS_P2 + w].ok  = r_repl[w] &&
                                        (r_ages[w*AGE_W +: AGE_W] != '0);
                node[WAYS_P2 + w].age = r_ages[(w % WAYS)*AGE_W +: AGE_W];
            end else begin
                node[WAYS_P2 + w].ok  = 1'b0;
                node[WAYS_P2 + w].age = '0;
            end
            node[WAYS_P2 + w].idx = WAY_W'(w);
        end
        for (int n = WAYS_P2 - 1; n >= 1; n--) begin
            if (node[2*n+1].ok && (!node[2*n].ok || node[2*n+1].age > node[2*n].age)) begin
                node[n] = node[2*n+1];
            end else begin
                node[n] = node[2*n];
            end
        end
        pick = node[1].ok ? node[1].idx : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_ages     = r_ages;
        n_att      = r_att;
        finish     = 1'b0;
        mem_we     = 1'b0;
        reject     = 1'b0;
        res_victim = '0;
        res_hitpos = '0;
        res_inv    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                    n_att   = '0;
                end
            end
            S_LOAD: begin
                n_ages  = r_rd_written ? r_rd_data : AGES_INIT;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd == CMD_HIT) begin
                    finish = 1'b1;
                    if ({1'b0, r_way} < (WAY_W + 1)'(WAYS)) begin
                        res_hitpos = age_of(r_ages, r_way);
                        n_ages     = to_mru(r_ages, r_way);
                        mem_we     = 1'b1;
                    end
                end else if (inv_found) begin
                    finish     = 1'b1;
                    mem_we     = 1'b1;
                    res_victim = inv_way;
                    res_inv    = 1'b1;
                    n_ages     = to_mru(r_ages, inv_way);
                end else begin
                    n_ages = to_mru(r_ages, pick);
                    reject = ((LIMIT_W'(r_att) + 1'b1) < r_limit) && r_lower[pick];
                    if (reject) begin
                        n_att = r_att + 1'b1;
                    end else begin
                        finish     = 1'b1;
                        mem_we     = 1'b1;
                        res_victim = pick;
                    end
                end
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state memory: read at accept, write back when the command finishes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[i_set_index];
        end
        if (mem_we) begin
            mem[r_set] <= n_ages;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_written   <= '0;
            r_cfg_limit <= LIMIT_W'(1);
            r_out_vld   <= 1'b0;
            r_att       <= '0;
        end else begin
            r_state   <= n_state;
            r_att     <= n_att;
            r_out_vld <= finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_limit <= i_cfg_data;
            end
            if (mem_we) begin
                r_written[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ages <= n_ages;
        if (accept) begin
            r_cmd        <= i_command;
            r_set        <= i_set_index;
            r_way        <= i_way;
            r_valid      <= i_valid_mask;
            r_repl       <= i_replaceable_mask;
            r_lower      <= i_lower_level_mask;
            r_rd_written <= r_written[i_set_index];
            if (r_cfg_limit == '0) begin
                r_limit <= LIMIT_W'(1);
            end else if (r_cfg_limit > LIMIT_W'(MAX_ATTEMPTS)) begin
                r_limit <= LIMIT_W'(MAX_ATTEMPTS);
            end else begin
                r_limit <= r_cfg_limit;
            end
        end
        if (finish) begin
            r_out_victim <= res_victim;
            r_out_hitpos <= res_hitpos;
            r_out_inv    <= res_inv;
            r_out_taken  <= res_inv ? '0 : r_att;
            r_out_rej    <= res_inv ? '0 : r_att;
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_victim_way    = r_out_victim;
    assign o_hit_position  = r_out_hitpos;
    assign o_used_invalid  = r_out_inv;
    assign o_attempt_taken = r_out_taken;
    assign o_rejections    = r_out_rej;

`ifndef SYNTHESIS
    a_result_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(r_state) == S_EXEC)
        else $error("result without a finishing command");

    a_rej_matches_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_rejections == o_attempt_taken)
        else $error("rejection count differs from accepted attempt");

    a_invalid_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_used_invalid |-> o_attempt_taken == '0)
        else $error("invalid-way victim after rejections");

    a_att_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> LIMIT_W'(r_att) < r_limit)
        else $error("attempt count passed the limit");

    a_exec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> $past(r_state) == S_LOAD || $past(r_state) == S_EXEC)
        else $error("selection entered without a memory read");
`endif

endmodule
